// ----- rtl/ppi_pkg.sv -----
// ----------------------------------------------------------------------------
// ppi_pkg
// Shared types, codes and helpers for the three-port parallel interface with
// port A strobed output handshake.
// ----------------------------------------------------------------------------
package ppi_pkg;

   // Beat kinds and register selects
   typedef enum logic [1:0] {
      KIND_READ   = 2'd0,
      KIND_WRITE  = 2'd1,
      KIND_ACK    = 2'd2,
      KIND_SRESET = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ADDR_A    = 2'd0,
      ADDR_B    = 2'd1,
      ADDR_C    = 2'd2,
      ADDR_CTRL = 2'd3
   } addr_type;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE_SET_CLEARS = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIN_A           = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIN_B           = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIN_C           = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRIVE_A         = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRIVE_B         = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRIVE_C         = 3'd6;

   // Reset values and control word fields
   localparam logic [7:0] CW_RESET       = 8'h9b;
   localparam logic [7:0] LATCH_RESET    = 8'hff;
   localparam logic [7:0] DRIVE_ALL_ONES = 8'hff;
   localparam logic [2:0] MODE_A_STROBED = 3'b010;
   localparam int unsigned CW_MODE_SET   = 7;
   localparam int unsigned CW_A_INPUT    = 4;
   localparam int unsigned CW_B_INPUT    = 1;
   localparam logic [2:0] BSR_INTE_A     = 3'd6;
   localparam int unsigned PC_OBF_N      = 7;
   localparam int unsigned PC_INTR_A     = 3;

   typedef struct packed {
      logic mode_set_clears;
      logic pin_a;
      logic pin_b;
      logic pin_c;
      logic drive_a;
      logic drive_b;
      logic drive_c;
   } cfg_type;

   typedef struct packed {
      kind_type   kind;
      addr_type   addr;
      logic [7:0] wdata;
      logic [7:0] pin_a;
      logic [7:0] pin_b;
      logic [7:0] pin_c;
   } req_type;

   typedef struct packed {
      logic [7:0] rdata;
      logic [7:0] out_a;
      logic       strobe_a;
      logic [7:0] out_b;
      logic       strobe_b;
      logic [7:0] out_c;
      logic       strobe_c;
   } rsp_type;

   typedef struct packed {
      logic [7:0] control_word;
      logic [7:0] latch_a;
      logic [7:0] latch_b;
      logic [7:0] latch_c;
      logic       buffer_full_a;
      logic       irq_a;
      logic       irq_enable_a;
   } state_type;

   localparam state_type STATE_RESET = '{
      control_word:  CW_RESET,
      latch_a:       LATCH_RESET,
      latch_b:       LATCH_RESET,
      latch_c:       LATCH_RESET,
      buffer_full_a: 1'b0,
      irq_a:         1'b0,
      irq_enable_a:  1'b0
   };

   // Port A strobed output mode
   function automatic logic strobed_a(input logic [7:0] cw);
      return cw[6:4] == MODE_A_STROBED;
   endfunction

   // Port C as seen on the pins, handshake bits merged in
   function automatic logic [7:0] port_c_view(input state_type s);
      logic [7:0] v;
      v = s.latch_c;
      if (strobed_a(s.control_word)) begin
         v[PC_OBF_N]  = ~s.buffer_full_a;
         v[PC_INTR_A] = s.irq_a;
      end
      return v;
   endfunction

endpackage

// ----- rtl/ppi_csr.sv -----
// ----------------------------------------------------------------------------
// ppi_csr
// Configuration registers, written one bit at a time through a plain write
// port. Writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module ppi_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [ppi_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic                                csr_wdata,
   output ppi_pkg::cfg_type                    cfg
);
   import ppi_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the register index
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_MODE_SET_CLEARS: cfg_in.mode_set_clears = csr_wdata;
            CSR_PIN_A:           cfg_in.pin_a           = csr_wdata;
            CSR_PIN_B:           cfg_in.pin_b           = csr_wdata;
            CSR_PIN_C:           cfg_in.pin_c           = csr_wdata;
            CSR_DRIVE_A:         cfg_in.drive_a         = csr_wdata;
            CSR_DRIVE_B:         cfg_in.drive_b         = csr_wdata;
            CSR_DRIVE_C:         cfg_in.drive_c         = csr_wdata;
            default:             cfg_in                 = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{mode_set_clears: 1'b1, pin_a: 1'b0, pin_b: 1'b0, pin_c: 1'b0,
                     drive_a: 1'b1, drive_b: 1'b1, drive_c: 1'b1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/ppi_in_stage.sv -----
// ----------------------------------------------------------------------------
// ppi_in_stage
// Input register: captures one request beat and holds it until the engine
// takes it.
// ----------------------------------------------------------------------------
module ppi_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ppi_pkg::req_type  req_data,
   input  logic              advance,
   output logic              in_valid,
   output ppi_pkg::req_type  in_data
);
   import ppi_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;
   logic    accept;

   // Stall only while a held beat cannot move on
   assign req_stall = valid_ff & ~advance;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_data;
      end
   end

   assign in_valid = valid_ff;
   assign in_data  = data_ff;

endmodule

// ----- rtl/ppi_engine.sv -----
// ----------------------------------------------------------------------------
// ppi_engine
// Port latches, control word and port A handshake flags; decodes one beat per
// cycle, taken when go is high, into the next state and the result beat.
// ----------------------------------------------------------------------------
module ppi_engine (
   input  logic              clock,
   input  logic              reset,
   input  ppi_pkg::cfg_type  cfg,
   input  logic              go,
   input  ppi_pkg::req_type  in_data,
   output ppi_pkg::rsp_type  rsp
);
   import ppi_pkg::*;

   state_type  st_ff;
   state_type  st_in;
   logic       do_a;
   logic [7:0] val_a;
   logic       do_b;
   logic [7:0] val_b;
   logic       do_c;
   logic       strobed;
   logic [2:0] bsr_sel;

   assign strobed = strobed_a(st_ff.control_word);
   assign bsr_sel = in_data.wdata[3:1];

   // Work out the state update and which ports are driven
   always_comb begin
      st_in      = st_ff;
      do_a       = 1'b0;
      val_a      = '0;
      do_b       = 1'b0;
      val_b      = '0;
      do_c       = 1'b0;
      rsp        = '0;
      unique case (in_data.kind)
         KIND_READ: begin
            unique case (in_data.addr)
               ADDR_A:    rsp.rdata = cfg.pin_a ? in_data.pin_a : st_ff.latch_a;
               ADDR_B:    rsp.rdata = cfg.pin_b ? in_data.pin_b : st_ff.latch_b;
               ADDR_C:    rsp.rdata = cfg.pin_c ? in_data.pin_c : st_ff.latch_c;
               ADDR_CTRL: rsp.rdata = st_ff.control_word;
            endcase
         end
         KIND_WRITE: begin
            unique case (in_data.addr)
               ADDR_A: begin
                  st_in.latch_a = in_data.wdata;
                  do_a          = 1'b1;
                  val_a         = in_data.wdata;
                  if (strobed) begin
                     st_in.buffer_full_a = 1'b1;
                     st_in.irq_a         = 1'b0;
                     do_c                = 1'b1;
                  end
               end
               ADDR_B: begin
                  st_in.latch_b = in_data.wdata;
                  do_b          = 1'b1;
                  val_b         = in_data.wdata;
               end
               ADDR_C: begin
                  st_in.latch_c = in_data.wdata;
                  do_c          = 1'b1;
               end
               ADDR_CTRL: begin
                  if (in_data.wdata[CW_MODE_SET]) begin
                     // Mode set
                     st_in.control_word = in_data.wdata;
                     if (cfg.mode_set_clears) begin
                        st_in.latch_a       = '0;
                        st_in.latch_b       = '0;
                        st_in.latch_c       = '0;
                        st_in.buffer_full_a = 1'b0;
                        st_in.irq_a         = 1'b0;
                        st_in.irq_enable_a  = 1'b0;
                        do_a                = ~in_data.wdata[CW_A_INPUT];
                        do_b                = ~in_data.wdata[CW_B_INPUT];
                        do_c                = 1'b1;
                     end
                  end else begin
                     // Port C bit set or reset
                     st_in.latch_c[bsr_sel] = in_data.wdata[0];
                     if (strobed && (bsr_sel == BSR_INTE_A)) begin
                        st_in.irq_enable_a = in_data.wdata[0];
                        st_in.irq_a        = in_data.wdata[0] & ~st_ff.buffer_full_a;
                     end
                     do_c = 1'b1;
                  end
               end
            endcase
         end
         KIND_ACK: begin
            if (strobed && st_ff.buffer_full_a) begin
               st_in.buffer_full_a = 1'b0;
               st_in.irq_a         = st_ff.irq_enable_a;
               do_c                = 1'b1;
            end
         end
         KIND_SRESET: begin
            st_in = STATE_RESET;
            do_a  = 1'b1;
            val_a = DRIVE_ALL_ONES;
            do_b  = 1'b1;
            val_b = DRIVE_ALL_ONES;
            do_c  = 1'b1;
         end
      endcase
      // Gate the strobes with the attached drives
      if (do_a && cfg.drive_a) begin
         rsp.strobe_a = 1'b1;
         rsp.out_a    = val_a;
      end
      if (do_b && cfg.drive_b) begin
         rsp.strobe_b = 1'b1;
         rsp.out_b    = val_b;
      end
      if (do_c && cfg.drive_c) begin
         rsp.strobe_c = 1'b1;
         rsp.out_c    = port_c_view(st_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= STATE_RESET;
      end else if (go) begin
         st_ff <= st_in;
      end
   end

   // A write to port A in strobed mode leaves the output buffer full
   assert property (@(posedge clock) disable iff (reset)
      go && in_data.kind == KIND_WRITE && in_data.addr == ADDR_A && strobed
      |=> st_ff.buffer_full_a && !st_ff.irq_a)
      else $error("buffer full not set by strobed port A write");

   // A soft reset returns the control word and latches
   assert property (@(posedge clock) disable iff (reset)
      go && in_data.kind == KIND_SRESET
      |=> st_ff.control_word == CW_RESET && st_ff.latch_c == LATCH_RESET
          && !st_ff.buffer_full_a)
      else $error("soft reset left state behind");

   // The interrupt never stands while the buffer is full
   assert property (@(posedge clock) disable iff (reset)
      st_ff.buffer_full_a |-> !st_ff.irq_a)
      else $error("port A interrupt raised with buffer full");

   // Outside strobed mode an acknowledge changes nothing
   assert property (@(posedge clock) disable iff (reset)
      go && in_data.kind == KIND_ACK && !strobed |=> $stable(st_ff))
      else $error("acknowledge acted outside strobed mode");

endmodule

// ----- rtl/ppi_rsp_stage.sv -----
// ----------------------------------------------------------------------------
// ppi_rsp_stage
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module ppi_rsp_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  ppi_pkg::rsp_type  rsp_data,
   output logic              advance,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ppi_pkg::rsp_type  rsp_out
);
   import ppi_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // Free when empty or when the held beat leaves this cycle
   assign advance = ~valid_ff | ~rsp_stall;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_out   = data_ff;

   // A result never gets overwritten while held
   assert property (@(posedge clock) disable iff (reset)
      load |-> advance)
      else $error("result register loaded while stalled");

endmodule

// ----- rtl/parallel_port_interface_mode1_out_top.sv -----
// ----------------------------------------------------------------------------
// parallel_port_interface_mode1_out_top
// Three-port parallel interface with port A strobed output handshake.
//
//   Channel | Direction | Handshake              | Payload
//   req     | in        | req_valid / req_stall  | kind, addr, wdata, pin_a..c
//   rsp     | out       | rsp_valid / rsp_stall  | rdata, out_a..c, strobe_a..c
//   csr     | in        | csr_write              | csr_index, csr_wdata
//
// One beat a cycle while rsp is not stalled; a request passes through the input
// register, then is decoded into the result register, which drives rsp.
// The state update for a beat happens as it leaves the input register.
// Reset is synchronous: returns the port state, flags and configuration to
// their reset values.
// A stall on rsp holds the result register and then the input register;
// req_stall rises only when both are full.
// ----------------------------------------------------------------------------
module parallel_port_interface_mode1_out_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_kind,
   input  logic [1:0]                          req_addr,
   input  logic [7:0]                          req_wdata,
   input  logic [7:0]                          req_pin_a,
   input  logic [7:0]                          req_pin_b,
   input  logic [7:0]                          req_pin_c,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_rdata,
   output logic [7:0]                          rsp_out_a,
   output logic                                rsp_strobe_a,
   output logic [7:0]                          rsp_out_b,
   output logic                                rsp_strobe_b,
   output logic [7:0]                          rsp_out_c,
   output logic                                rsp_strobe_c,
   input  logic                                csr_write,
   input  logic [ppi_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic                                csr_wdata
);
   import ppi_pkg::*;

   cfg_type cfg;
   req_type req_data;
   req_type in_data;
   rsp_type rsp_next;
   rsp_type rsp_out;
   logic    in_valid;
   logic    advance;
   logic    go;

   // Pack the request beat
   assign req_data = '{kind:  kind_type'(req_kind),
                       addr:  addr_type'(req_addr),
                       wdata: req_wdata,
                       pin_a: req_pin_a,
                       pin_b: req_pin_b,
                       pin_c: req_pin_c};

   // Move a held beat on when the result register has room
   assign go = in_valid & advance;

   ppi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ppi_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .advance   (advance),
      .in_valid  (in_valid),
      .in_data   (in_data)
   );

   ppi_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .go      (go),
      .in_data (in_data),
      .rsp     (rsp_next)
   );

   ppi_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (go),
      .rsp_data  (rsp_next),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_out   (rsp_out)
   );

   // Unpack the result beat
   assign rsp_rdata    = rsp_out.rdata;
   assign rsp_out_a    = rsp_out.out_a;
   assign rsp_strobe_a = rsp_out.strobe_a;
   assign rsp_out_b    = rsp_out.out_b;
   assign rsp_strobe_b = rsp_out.strobe_b;
   assign rsp_out_c    = rsp_out.out_c;
   assign rsp_strobe_c = rsp_out.strobe_c;

   // The input side stalls only behind a full, stalled result register
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall && in_valid)
      else $error("request stalled with room downstream");

endmodule
